// ===== hdl/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the cartridge bank mapper with scanline IRQ.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int unsigned AddrWidth = 16;
  localparam int unsigned DataWidth = 8;
  localparam int unsigned RomWidth  = 21;
  localparam int unsigned BankWidth = 8;
  localparam int unsigned ChrCount  = 6;

  localparam logic [BankWidth-1:0] LastPrgBankReset = 8'd63;

  typedef enum logic [1:0] {
    MODE_CPU_WRITE  = 2'd0,
    MODE_TICK       = 2'd1,
    MODE_CPU_LOOKUP = 2'd2,
    MODE_PPU_LOOKUP = 2'd3
  } mode_t;

  // Write decode key: {address[15:12], address[1:0]}
  typedef logic [5:0] wr_key_t;
  localparam wr_key_t WrPrg0    = 6'b1000_00;
  localparam wr_key_t WrPrg1    = 6'b1000_01;
  localparam wr_key_t WrChr0    = 6'b1000_10;
  localparam wr_key_t WrChr1    = 6'b1000_11;
  localparam wr_key_t WrChr2    = 6'b1010_00;
  localparam wr_key_t WrChr3    = 6'b1010_01;
  localparam wr_key_t WrChr4    = 6'b1010_10;
  localparam wr_key_t WrChr5    = 6'b1010_11;
  localparam wr_key_t WrLatch   = 6'b1100_00;
  localparam wr_key_t WrReload  = 6'b1100_01;
  localparam wr_key_t WrIrqOff  = 6'b1100_10;
  localparam wr_key_t WrIrqOn   = 6'b1100_11;
  localparam wr_key_t WrMirror  = 6'b1110_00;

  localparam int unsigned MirrorBit = 6;

  typedef struct packed {
    mode_t                mode;
    logic [AddrWidth-1:0] address;
    logic [DataWidth-1:0] data;
  } req_t;

  typedef struct packed {
    logic                mirroring;
    logic                irq_pulse;
    logic [RomWidth-1:0] rom_address;
  } res_t;

  typedef struct packed {
    logic irq_enabled;
    logic early_mirror_path;
  } status_t;

endpackage

// ===== hdl/cbm_core.sv =====
// ----------------------------------------------------------------------------
// cbm_core
// Mapper registers, write decode, IRQ counter and address translation.
// ----------------------------------------------------------------------------
module cbm_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  cbm_pkg::req_t                     req,
  input  logic [cbm_pkg::BankWidth-1:0]     last_prg_bank,
  output cbm_pkg::res_t                     res,
  output cbm_pkg::status_t                  status
);

  logic [cbm_pkg::BankWidth-1:0] prg_banks [2];
  logic [cbm_pkg::BankWidth-1:0] chr_banks [cbm_pkg::ChrCount];
  logic [cbm_pkg::BankWidth-1:0] irq_latch;
  logic [cbm_pkg::BankWidth-1:0] irq_counter;
  logic                          irq_enabled;
  logic                          early_path;
  logic                          mirror;

  logic [cbm_pkg::BankWidth-1:0] prg_banks_next [2];
  logic [cbm_pkg::BankWidth-1:0] chr_banks_next [cbm_pkg::ChrCount];
  logic [cbm_pkg::BankWidth-1:0] irq_latch_next;
  logic [cbm_pkg::BankWidth-1:0] irq_counter_next;
  logic                          irq_enabled_next;
  logic                          early_path_next;
  logic                          mirror_next;
  logic                          pulse;

  cbm_pkg::wr_key_t              key;
  logic [cbm_pkg::BankWidth-1:0] prg_bank_sel;
  logic [cbm_pkg::BankWidth-1:0] chr_bank_sel;
  logic [12:0]                   ppu_addr;
  logic [cbm_pkg::RomWidth-1:0]  rom;
  logic                          bit6;

  assign key  = {req.address[15:12], req.address[1:0]};
  assign bit6 = req.data[cbm_pkg::MirrorBit];

  always_comb begin
    prg_banks_next   = prg_banks;
    chr_banks_next   = chr_banks;
    irq_latch_next   = irq_latch;
    irq_counter_next = irq_counter;
    irq_enabled_next = irq_enabled;
    early_path_next  = early_path;
    mirror_next      = mirror;
    pulse            = 1'b0;
    unique case (req.mode)
      cbm_pkg::MODE_CPU_WRITE: begin
        unique case (key)
          cbm_pkg::WrPrg0: begin
            prg_banks_next[0] = req.data;
            if (early_path) mirror_next = bit6;
          end
          cbm_pkg::WrPrg1:   prg_banks_next[1] = req.data;
          cbm_pkg::WrChr0:   chr_banks_next[0] = req.data;
          cbm_pkg::WrChr1:   chr_banks_next[1] = req.data;
          cbm_pkg::WrChr2:   chr_banks_next[2] = req.data;
          cbm_pkg::WrChr3:   chr_banks_next[3] = req.data;
          cbm_pkg::WrChr4:   chr_banks_next[4] = req.data;
          cbm_pkg::WrChr5:   chr_banks_next[5] = req.data;
          cbm_pkg::WrLatch:  irq_latch_next = req.data;
          cbm_pkg::WrReload: irq_counter_next = irq_latch;
          cbm_pkg::WrIrqOff: irq_enabled_next = 1'b0;
          cbm_pkg::WrIrqOn:  irq_enabled_next = 1'b1;
          cbm_pkg::WrMirror: begin
            early_path_next = 1'b0;
            mirror_next     = bit6;
          end
          default: ;
        endcase
      end
      cbm_pkg::MODE_TICK: begin
        if (irq_enabled) begin
          irq_counter_next = irq_counter + 8'd1;
          // wrap past 0xFF fires the interrupt and stops counting
          if (&irq_counter) begin
            irq_enabled_next = 1'b0;
            pulse            = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // address translation
  assign ppu_addr = req.address[12:0];

  always_comb begin
    unique case (req.address[14:13])
      2'd0:    prg_bank_sel = prg_banks[0];
      2'd1:    prg_bank_sel = prg_banks[1];
      2'd2:    prg_bank_sel = last_prg_bank - 8'd1;
      default: prg_bank_sel = last_prg_bank;
    endcase
    if (!ppu_addr[12]) chr_bank_sel = chr_banks[{2'b00, ppu_addr[11]}];
    else chr_bank_sel = chr_banks[3'd2 + {1'b0, ppu_addr[11:10]}];
  end

  always_comb begin
    unique case (req.mode)
      cbm_pkg::MODE_CPU_LOOKUP: begin
        if (req.address[15]) rom = {prg_bank_sel, req.address[12:0]};
        else rom = '0;
      end
      cbm_pkg::MODE_PPU_LOOKUP: begin
        if (!ppu_addr[12]) rom = {2'b00, chr_bank_sel, ppu_addr[10:0]};
        else rom = {3'b000, chr_bank_sel, ppu_addr[9:0]};
      end
      default: rom = '0;
    endcase
  end

  assign res.rom_address = rom;
  assign res.irq_pulse   = pulse;
  assign res.mirroring   = mirror_next;

  assign status.irq_enabled       = irq_enabled;
  assign status.early_mirror_path = early_path;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks   <= '{default: '0};
      chr_banks   <= '{default: '0};
      irq_latch   <= '0;
      irq_counter <= '0;
      irq_enabled <= 1'b0;
      early_path  <= 1'b1;
      mirror      <= 1'b0;
    end else if (fire) begin
      prg_banks   <= prg_banks_next;
      chr_banks   <= chr_banks_next;
      irq_latch   <= irq_latch_next;
      irq_counter <= irq_counter_next;
      irq_enabled <= irq_enabled_next;
      early_path  <= early_path_next;
      mirror      <= mirror_next;
    end
  end

endmodule

// ===== hdl/cartridge_bank_mapper_irq_top.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_top
// Bank mapper with scanline IRQ counter: bus writes, ticks and ROM lookups.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata {data, address}, tuser mode
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata {mirror, irq, rom_address}
//  cfg       in   cfg_valid / cfg_ready          cfg_data last_prg_bank
//
//  One request per cycle when the result side does not stall; the path is an input
//  register, then decode and translation into the result register.
//  Reset: all bank registers 0, IRQ off, early mirror path on, last bank 63.
//  A stalled result holds; the input register still takes one more request.
//  cfg_ready is always high.
module cartridge_bank_mapper_irq_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] data
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] rom_address, [21] irq_pulse,
                                      // [22] mirroring, [23] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic                          in_valid;
  cbm_pkg::req_t                 in_req;
  logic                          out_valid;
  cbm_pkg::res_t                 out_res;
  logic                          out_open;
  logic                          fire;
  logic [cbm_pkg::BankWidth-1:0] last_prg_bank;
  cbm_pkg::res_t                 res;
  cbm_pkg::status_t              status;

  assign out_open      = !out_valid || m_axis_tready;
  assign fire          = in_valid && out_open;
  assign s_axis_tready = !in_valid || out_open;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      last_prg_bank <= cbm_pkg::LastPrgBankReset;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (out_open) out_valid <= in_valid;
      if (cfg_valid) last_prg_bank <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req.mode    <= cbm_pkg::mode_t'(s_axis_tuser);
      in_req.address <= s_axis_tdata[15:0];
      in_req.data    <= s_axis_tdata[23:16];
    end
    if (fire) out_res <= res;
  end

  cbm_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .req           (in_req),
    .last_prg_bank (last_prg_bank),
    .res           (res),
    .status        (status)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res};

  // interrupt pulse always leaves counting disabled
  a_pulse_disables: assert property (@(posedge clk) disable iff (rst)
    fire && res.irq_pulse |=> !status.irq_enabled)
    else $error("irq pulse without counter disable");

  // only ticks may raise the interrupt
  a_pulse_tick_only: assert property (@(posedge clk) disable iff (rst)
    fire && res.irq_pulse |-> in_req.mode == cbm_pkg::MODE_TICK)
    else $error("irq pulse outside a tick");

  // once the 0xE000 write closes the early path it stays closed
  a_early_path_sticky: assert property (@(posedge clk) disable iff (rst)
    !status.early_mirror_path |=> !status.early_mirror_path)
    else $error("early mirror path reopened");

  a_no_rom_on_write: assert property (@(posedge clk) disable iff (rst)
    fire && (in_req.mode == cbm_pkg::MODE_CPU_WRITE || in_req.mode == cbm_pkg::MODE_TICK)
    |-> res.rom_address == '0)
    else $error("rom address on non-lookup request");

endmodule

// ===== verif/tb_cartridge_bank_mapper_irq_top.sv =====
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_irq_top
// Drives bus writes, scanline ticks and ROM lookups through the stream port.
// Every reply is checked against a behavioral mapper kept in the scoreboard.
// The run steps through several last-bank settings and stalls both sides.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_irq_top;

  localparam int unsigned WatchdogLimit = 2000;

  localparam cbm_pkg::wr_key_t WriteKeys [13] = '{
    cbm_pkg::WrPrg0, cbm_pkg::WrPrg1, cbm_pkg::WrChr0, cbm_pkg::WrChr1,
    cbm_pkg::WrChr2, cbm_pkg::WrChr3, cbm_pkg::WrChr4, cbm_pkg::WrChr5,
    cbm_pkg::WrLatch, cbm_pkg::WrReload, cbm_pkg::WrIrqOff, cbm_pkg::WrIrqOn,
    cbm_pkg::WrMirror};

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_COIN} rx_style_e;

  class mapper_scoreboard;
    logic [7:0] last_bank;
    logic [7:0] prg_bank [2];
    logic [7:0] chr_bank [cbm_pkg::ChrCount];
    logic [7:0] irq_latch;
    logic [7:0] irq_count;
    logic       irq_armed;
    logic       early_mirror;
    logic       mirror_h;
    cbm_pkg::res_t mapper_replies [$];
    int unsigned n_requests;
    int unsigned n_replies;
    int unsigned n_errors;
    int unsigned n_pulses;
    int unsigned n_settings;
    int unsigned n_mode [4];

    function new();
      last_bank    = cbm_pkg::LastPrgBankReset;
      prg_bank     = '{default: '0};
      chr_bank     = '{default: '0};
      irq_latch    = '0;
      irq_count    = '0;
      irq_armed    = 1'b0;
      early_mirror = 1'b1;
      mirror_h     = 1'b0;
    endfunction

    // Advance the mapper state by one request and queue the reply it gives.
    function void apply_bus_request(input cbm_pkg::mode_t m, input logic [15:0] a,
                                    input logic [7:0] d);
      cbm_pkg::res_t    r;
      cbm_pkg::wr_key_t key;
      logic [12:0]      pa;
      logic [7:0]       bank;
      r   = '0;
      key = {a[15:12], a[1:0]};
      pa  = a[12:0];
      n_requests++;
      n_mode[m]++;
      case (m)
        cbm_pkg::MODE_CPU_WRITE: begin
          case (key)
            cbm_pkg::WrPrg0: begin
              prg_bank[0] = d;
              if (early_mirror) mirror_h = d[cbm_pkg::MirrorBit];
            end
            cbm_pkg::WrPrg1:   prg_bank[1] = d;
            cbm_pkg::WrChr0:   chr_bank[0] = d;
            cbm_pkg::WrChr1:   chr_bank[1] = d;
            cbm_pkg::WrChr2:   chr_bank[2] = d;
            cbm_pkg::WrChr3:   chr_bank[3] = d;
            cbm_pkg::WrChr4:   chr_bank[4] = d;
            cbm_pkg::WrChr5:   chr_bank[5] = d;
            cbm_pkg::WrLatch:  irq_latch = d;
            cbm_pkg::WrReload: irq_count = irq_latch;
            cbm_pkg::WrIrqOff: irq_armed = 1'b0;
            cbm_pkg::WrIrqOn:  irq_armed = 1'b1;
            cbm_pkg::WrMirror: begin
              early_mirror = 1'b0;
              mirror_h     = d[cbm_pkg::MirrorBit];
            end
            default: ;
          endcase
        end
        cbm_pkg::MODE_TICK: begin
          if (irq_armed) begin
            irq_count = irq_count + 8'd1;
            if (irq_count == 8'd0) begin
              irq_armed   = 1'b0;
              r.irq_pulse = 1'b1;
              n_pulses++;
            end
          end
        end
        cbm_pkg::MODE_CPU_LOOKUP: begin
          // below 0x8000 there is no program ROM: answer stays zero
          if (a[15]) begin
            case (a[14:13])
              2'd0:    bank = prg_bank[0];
              2'd1:    bank = prg_bank[1];
              2'd2:    bank = last_bank - 8'd1;  // wraps to 255 when last bank is 0
              default: bank = last_bank;
            endcase
            r.rom_address = {bank, a[12:0]};
          end
        end
        cbm_pkg::MODE_PPU_LOOKUP: begin
          if (!pa[12]) r.rom_address = 21'({chr_bank[pa[11]], pa[10:0]});
          else         r.rom_address = 21'({chr_bank[2 + pa[11:10]], pa[9:0]});
        end
      endcase
      r.mirroring = mirror_h;
      mapper_replies.push_back(r);
    endfunction

    function void compare_reply(input logic [23:0] word);
      cbm_pkg::res_t got;
      cbm_pkg::res_t want;
      got = cbm_pkg::res_t'(word[22:0]);
      n_replies++;
      if (mapper_replies.size() == 0) begin
        $error("reply with no request outstanding: tdata 0x%06h", word);
        n_errors++;
        return;
      end
      want = mapper_replies.pop_front();
      if (got.rom_address !== want.rom_address) begin
        $error("rom_address: expected 0x%06h, actual 0x%06h",
               want.rom_address, got.rom_address);
        n_errors++;
      end
      if (got.irq_pulse !== want.irq_pulse) begin
        $error("irq_pulse: expected %0b, actual %0b", want.irq_pulse, got.irq_pulse);
        n_errors++;
      end
      if (got.mirroring !== want.mirroring) begin
        $error("mirroring: expected %0b, actual %0b",
               want.mirroring, got.mirroring);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [15:0] address, [23:16] data
  logic [1:0]  s_axis_tuser;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [20:0] rom_address, [21] irq_pulse, [22] mirroring
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  mapper_scoreboard sb = new();

  int unsigned burst_left = 8;
  bit          offering = 1'b0;
  int unsigned quiet_cycles = 0;

  cartridge_bank_mapper_irq_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.apply_bus_request(cbm_pkg::mode_t'(s_axis_tuser), s_axis_tdata[15:0],
                             s_axis_tdata[23:16]);
      if (m_axis_tvalid && m_axis_tready) sb.compare_reply(m_axis_tdata);
      if (cfg_valid && cfg_ready) begin
        sb.last_bank = cfg_data;
        sb.n_settings++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WatchdogLimit) begin
      $display("Timeout: no request moved for %0d cycles, %0d replies outstanding",
               WatchdogLimit, sb.mapper_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: changing stall styles plus two long hold-offs to back up the pipe.
  initial begin
    int unsigned cyc;
    int unsigned hold_left;
    bit [1:0]    holds_done;
    rx_style_e   style;
    cyc        = 0;
    hold_left  = 0;
    holds_done = '0;
    style      = RX_FREE;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 97 == 0) style = rx_style_e'($urandom_range(0, 3));
      if (!holds_done[0] && sb.n_requests >= 400) begin
        hold_left     = 150;
        holds_done[0] = 1'b1;
      end else if (!holds_done[1] && sb.n_requests >= 1100) begin
        hold_left     = 90;
        holds_done[1] = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (style)
          RX_FREE:     m_axis_tready <= 1'b1;
          RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: m_axis_tready <= (cyc % 3 == 0);
          RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  function automatic logic [15:0] key_address(input cbm_pkg::wr_key_t k);
    return {k[5:2], 10'($urandom), k[1:0]};
  endfunction

  // Offer one request and hold it until taken; bursts end in a short random gap.
  task automatic send_request(input cbm_pkg::mode_t m, input logic [15:0] a,
                              input logic [7:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {d, a};
    offering = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (burst_left > 1) burst_left--;
    else begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 25 : 4)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
  endtask

  task automatic drain_replies();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    // let the request taken at this edge reach the scoreboard first
    @(posedge clk);
    while (sb.mapper_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_last_bank(input logic [7:0] v);
    drain_replies();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_traffic(input int unsigned goal);
    int unsigned sent;
    int unsigned pick;
    int unsigned ticks;
    logic [15:0] a;
    sent = 0;
    while (sent < goal) begin
      pick = $urandom_range(0, 99);
      a    = 16'($urandom);
      if (pick < 6) begin
        // arm the counter close to the top so the wrap comes within a few ticks
        send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrLatch),
                     8'($urandom_range(8'hE0, 8'hFF)));
        send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrReload),
                     8'($urandom));
        send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrIrqOn),
                     8'($urandom));
        ticks = $urandom_range(1, 40);
        repeat (ticks) send_request(cbm_pkg::MODE_TICK, 16'($urandom), 8'($urandom));
        sent += 3 + ticks;
      end else begin
        if (pick < 40)
          send_request(cbm_pkg::MODE_CPU_WRITE,
                       key_address(WriteKeys[$urandom_range(0, 12)]), 8'($urandom));
        else if (pick < 48) send_request(cbm_pkg::MODE_CPU_WRITE, a, 8'($urandom));
        else if (pick < 68) send_request(cbm_pkg::MODE_TICK, a, 8'($urandom));
        else if (pick < 84)
          send_request(cbm_pkg::MODE_CPU_LOOKUP,
                       ($urandom_range(0, 4) == 0) ? a : {1'b1, a[14:0]}, 8'($urandom));
        else
          send_request(cbm_pkg::MODE_PPU_LOOKUP,
                       ($urandom_range(0, 3) == 0) ? a : {3'b000, a[12:0]}, 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [7:0] bank_plan [5];
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= cbm_pkg::MODE_TICK;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    bank_plan = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 254)),
                  cbm_pkg::LastPrgBankReset};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request(cbm_pkg::MODE_CPU_LOOKUP, 16'h7FFF, 8'h00);  // no program ROM below 0x8000
    send_request(cbm_pkg::MODE_CPU_LOOKUP, 16'hFFFF, 8'hFF);  // fixed top window
    send_request(cbm_pkg::MODE_PPU_LOOKUP, 16'hFFFF, 8'h00);  // upper ppu bits dropped
    send_request(cbm_pkg::MODE_TICK, 16'h0000, 8'h00);        // counting still off
    // early path sets mirroring
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrPrg0), 8'hFF);
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrPrg1), 8'hAA);
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrChr0), 8'h55);
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrChr1), 8'hFF);
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrChr2), 8'h01);
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrChr3), 8'h80);
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrChr4), 8'h7F);
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrChr5), 8'hFE);
    send_request(cbm_pkg::MODE_CPU_WRITE, 16'h9000, 8'hFF);   // unmapped
    send_request(cbm_pkg::MODE_CPU_WRITE, 16'hE001, 8'hFF);   // unmapped
    send_request(cbm_pkg::MODE_CPU_WRITE, 16'h0000, 8'hFF);   // below the register space
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrLatch), 8'hFE);
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrReload), 8'h00);
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrIrqOn), 8'h00);
    send_request(cbm_pkg::MODE_TICK, 16'hFFFF, 8'hFF);
    send_request(cbm_pkg::MODE_TICK, 16'h0000, 8'h00);        // wraps: pulse and stop
    send_request(cbm_pkg::MODE_TICK, 16'h0000, 8'h00);
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrIrqOff), 8'h00);
    // closes early path
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrMirror), 8'h00);
    // mirroring must hold
    send_request(cbm_pkg::MODE_CPU_WRITE, key_address(cbm_pkg::WrPrg0), 8'h40);
    send_request(cbm_pkg::MODE_CPU_LOOKUP, 16'hA000, 8'h00);
    send_request(cbm_pkg::MODE_PPU_LOOKUP, 16'h0800, 8'h00);
    send_request(cbm_pkg::MODE_PPU_LOOKUP, 16'h1C00, 8'h00);
    send_random_traffic(250);

    foreach (bank_plan[i]) begin
      write_last_bank(bank_plan[i]);
      send_request(cbm_pkg::MODE_CPU_LOOKUP, {3'b110, 13'($urandom)}, 8'h00);
      send_request(cbm_pkg::MODE_CPU_LOOKUP, {3'b111, 13'($urandom)}, 8'hFF);
      send_random_traffic(260);
    end

    drain_replies();
    repeat (8) @(posedge clk);

    $display("Ran %0d requests: %0d writes, %0d ticks, %0d cpu and %0d ppu lookups.",
             sb.n_requests, sb.n_mode[cbm_pkg::MODE_CPU_WRITE],
             sb.n_mode[cbm_pkg::MODE_TICK], sb.n_mode[cbm_pkg::MODE_CPU_LOOKUP],
             sb.n_mode[cbm_pkg::MODE_PPU_LOOKUP]);
    $display("Saw %0d IRQ pulses across %0d last-bank settings; %0d replies checked.",
             sb.n_pulses, sb.n_settings + 1, sb.n_replies);
    if (sb.n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
